/* design/lhmr_pkg.sv */
// Shared types and constants for the link handshake message receiver.
// Holds operation codes, link mode codes, control bytes and the store access struct.
// No dependencies.
package lhmr_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_ARM     = 2'd1;
  localparam logic [1:0] OP_SWITCH  = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // Link modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_SEND = 2'd2;

  // Control bytes on the link.
  localparam logic [7:0] BYTE_ETB   = 8'h00;
  localparam logic [7:0] BYTE_RMODE = 8'h01;
  localparam logic [7:0] BYTE_ENQ   = 8'h05;
  localparam logic [7:0] BYTE_ACK   = 8'h06;
  localparam logic [7:0] BYTE_CAN   = 8'h18;

  localparam logic [7:0] RATE_RESET = 8'h01;

  // Access request from the control stage to the message store.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wr_data;
  } store_req_t;

endpackage

/* design/link_handshake_message_receiver.sv */
// Slave side of a byte-exchange link that collects handshaked messages.
// Channels: the input beat carries op in s_axis_tuser and rx_byte/read_index
// in s_axis_tdata; each accepted beat produces exactly one result beat on the
// m_axis group. The rate register is written through cfg_we_i/cfg_wdata_i.
// Pipeline: a result passes through the stage 1 register and then the output register.
// Throughput: one beat per cycle unless m_axis_tready stalls the output. The mode,
// flags and counters update in the accept cycle; the single message memory takes
// one write (received data byte) or one read (character read) per beat, and its
// registered read port loads with the stage 1 register. A read after a write to
// the same entry sees the new byte, since the write lands at the accepting edge.
// Reset: mode idle, flags and counters cleared, rate setting 1, no result
// pending. The memory is not cleared; only entries below the stored length are
// ever returned, all written by the last message.
// Stall: a pending result sits in the output register while the control stage
// keeps one more beat, so input is taken until both are full.
module link_handshake_message_receiver import lhmr_pkg::*; #(
  parameter int MSG_DEPTH = 144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [7:0] rx_byte, [15:8] read_index
  input  logic [15:0] s_axis_tdata,
  // tuser: [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [7:0] reply_byte, [9:8] link_mode, [10] message_done,
  //        [18:11] message_length, [26:19] read_data, [31:27] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int AW   = $clog2(MSG_DEPTH);
  localparam int CW   = $clog2(MSG_DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  // Control state.
  logic [1:0]    mode_q, mode_d;
  logic          pend_q, pend_d;
  logic          armed_q, armed_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] vlen_q, vlen_d;
  logic [7:0]    rate_q;

  // Stage 1 result (everything but read data).
  logic          s1_valid_q;
  logic [7:0]    s1_reply_q;
  logic [1:0]    s1_mode_q;
  logic          s1_done_q;
  logic [7:0]    s1_len_q;
  logic          s1_rd_ok_q;

  // Output register.
  logic          out_valid_q;
  logic [31:0]   out_data_q;

  logic          in_acc, s1_adv;
  logic [1:0]    op;
  logic [7:0]    rx, idx;
  logic [7:0]    reply;
  logic          done;
  logic          rd_ok;
  store_req_t    req;
  logic [7:0]    rd_data;

  assign op = s_axis_tuser;
  assign rx = s_axis_tdata[7:0];
  assign idx = s_axis_tdata[15:8];

  assign s1_adv = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // The mode rules are applied in the same order as the protocol steps, so a
  // byte that changes the mode can be handled again under the new one.
  always_comb begin
    logic [1:0] m;
    logic       p;
    m = mode_q;
    p = pend_q;
    mode_d = mode_q;
    pend_d = pend_q;
    armed_d = armed_q;
    count_d = count_q;
    vlen_d = vlen_q;
    reply = '0;
    done = 1'b0;
    req = '0;
    req.wr_data = rx;
    rd_ok = 1'b0;
    unique case (op)
      OP_RX_BYTE: begin
        if (m == MODE_IDLE && p) begin
          if (rx == BYTE_RMODE) begin
            p = 1'b0;
            m = MODE_SEND;
          end else begin
            reply = BYTE_CAN;
          end
        end
        if (m == MODE_IDLE && !p && rx == BYTE_ENQ && armed_q) begin
          reply = BYTE_ACK;
          m = MODE_RECV;
          armed_d = 1'b0;
        end
        if (m == MODE_RECV) begin
          if (rx == BYTE_ETB) begin
            vlen_d = count_q;
            count_d = '0;
            m = MODE_IDLE;
            done = 1'b1;
          end else if (rx != BYTE_ENQ && rx != BYTE_ACK &&
                       count_q < CW'(MSG_DEPTH)) begin
            req.wr_en = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        if (m == MODE_SEND && p) begin
          if (rx == BYTE_ENQ) begin
            p = 1'b0;
            m = MODE_IDLE;
          end else begin
            reply = BYTE_CAN;
          end
        end
        if (m == MODE_SEND && !p && rx == BYTE_RMODE) begin
          reply = rate_q;
        end
        mode_d = m;
        pend_d = p;
      end
      OP_ARM:    armed_d = 1'b1;
      OP_SWITCH: pend_d = 1'b1;
      OP_READ: begin
        req.rd_en = 1'b1;
        rd_ok = CMPW'(idx) < CMPW'(vlen_q);
      end
      default: ;
    endcase
    if (!in_acc) begin
      req.wr_en = 1'b0;
      req.rd_en = 1'b0;
    end
  end

  lhmr_msg_store #(
    .MSG_DEPTH(MSG_DEPTH),
    .AW       (AW)
  ) u_store (
    .clk_i    (clk_i),
    .req_i    (req),
    .wr_addr_i(count_q[AW-1:0]),
    .rd_addr_i(AW'(idx)),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= 1'b0;
      armed_q <= 1'b0;
      count_q <= '0;
      vlen_q <= '0;
      rate_q <= RATE_RESET;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        armed_q <= armed_d;
        count_q <= count_d;
        vlen_q <= vlen_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_reply_q <= reply;
      s1_mode_q <= mode_d;
      s1_done_q <= done;
      s1_len_q <= 8'(vlen_d);
      s1_rd_ok_q <= rd_ok;
    end
    if (s1_adv) begin
      out_data_q <= {5'd0, (s1_rd_ok_q ? rd_data : 8'd0), s1_len_q,
                     s1_done_q, s1_mode_q, s1_reply_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MSG_DEPTH) && vlen_q <= CW'(MSG_DEPTH))
    else $error("byte count or stored length beyond store depth");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("link mode holds an unused code");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[10] |-> out_data_q[9:8] == MODE_IDLE)
    else $error("message end reported outside idle mode");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(rd_data))
    else $error("read data moved while its beat was stalled");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done |=> count_q == '0)
    else $error("byte count not cleared at end of message");

endmodule

/* design/lhmr_msg_store.sv */
// Message store of the link handshake message receiver.
// Single synchronous memory, one write and one registered read per cycle.
// Depends on lhmr_pkg for the access request struct.
module lhmr_msg_store import lhmr_pkg::*; #(
  parameter int MSG_DEPTH = 144,
  parameter int AW        = 8
) (
  input  logic          clk_i,
  input  store_req_t    req_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [MSG_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= req_i.wr_data;
    end
  end

  // The read register only moves on a read, so it holds while the result stalls.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
